// ----- sv/tss_pkg.sv -----
// Shared types, widths and codes for the timed step sequencer.
// Depends on nothing; every other file imports it.
package tss_pkg;

  localparam int MAX_STEPS   = 16;
  localparam int STEP_IDX_W  = $clog2(MAX_STEPS);
  localparam int STEP_CNT_W  = $clog2(MAX_STEPS + 1);
  localparam int MODE_W      = 3;
  localparam int ADDR_W      = 4;
  localparam int KIND_W      = 2;
  localparam int SERVO_W     = 8;
  localparam int PRESET_W    = 4;
  localparam int DELAY_W     = 32;
  localparam int ACTION_W    = 4;
  localparam int COUNT_W     = 5;
  localparam int STEP_NOW_W  = 5;

  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CONFIRM = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ABORT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_SERVO  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELAY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACTION = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WAIT   = 2'd3;

  localparam logic [ACTION_W-1:0] ACT_NONE   = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_IGNITE = 4'd1;

  localparam logic [DELAY_W-1:0] ELAPSED_MAX = '1;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SERVO_W-1:0]  servo;
    logic [PRESET_W-1:0] preset;
    logic [DELAY_W-1:0]  delay;
    logic [ACTION_W-1:0] action;
  } step_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   step_addr;
    logic [COUNT_W-1:0]  step_count;
    step_t               entry;
  } item_t;

  typedef struct packed {
    logic                  en;
    logic [STEP_IDX_W-1:0] addr;
    step_t                 data;
  } tbl_wr_t;

  typedef struct packed {
    logic                  servo_cmd;
    logic [SERVO_W-1:0]    out_servo;
    logic [PRESET_W-1:0]   out_preset;
    logic                  fire_line;
    logic                  action_strobe;
    logic [ACTION_W-1:0]   out_action;
    logic                  busy_res;
    logic                  awaiting_confirm;
    logic                  sequence_done;
    logic [STEP_NOW_W-1:0] step_now;
  } result_t;

endpackage

// ----- sv/tss_ifs.sv -----
// Valid/ready channel interfaces for sequencer events and results.
// Depends on tss_pkg for field widths.
interface tss_in_if import tss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ADDR_W-1:0]   step_addr;
  logic [KIND_W-1:0]   step_kind;
  logic [SERVO_W-1:0]  servo_select;
  logic [PRESET_W-1:0] preset_index;
  logic [DELAY_W-1:0]  hold_ms;
  logic [ACTION_W-1:0] action_code;
  logic [COUNT_W-1:0]  step_count;

  modport source (output valid, mode, step_addr, step_kind, servo_select, preset_index,
                  hold_ms, action_code, step_count, input ready);
  modport sink (input valid, mode, step_addr, step_kind, servo_select, preset_index,
                hold_ms, action_code, step_count, output ready);
endinterface

interface tss_out_if import tss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  servo_cmd;
  logic [SERVO_W-1:0]    out_servo;
  logic [PRESET_W-1:0]   out_preset;
  logic                  fire_line;
  logic                  action_strobe;
  logic [ACTION_W-1:0]   out_action;
  logic                  busy_res;
  logic                  awaiting_confirm;
  logic                  sequence_done;
  logic [STEP_NOW_W-1:0] step_now;

  modport source (output valid, servo_cmd, out_servo, out_preset, fire_line, action_strobe,
                  out_action, busy_res, awaiting_confirm, sequence_done, step_now,
                  input ready);
  modport sink (input valid, servo_cmd, out_servo, out_preset, fire_line, action_strobe,
                out_action, busy_res, awaiting_confirm, sequence_done, step_now,
                output ready);
endinterface

// ----- sv/tss_step_mem.sv -----
// Step table: single-port-write, single-read synchronous memory with a registered read.
// Depends on tss_pkg; bypasses a same-cycle write to the read port.
module tss_step_mem import tss_pkg::*; (
  input  logic                  clk_i,
  input  tbl_wr_t               wr_i,
  input  logic [STEP_IDX_W-1:0] rd_addr_i,
  output step_t                 rd_data_o
);

  step_t mem [MAX_STEPS];
  step_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Forward write data when the read hits the entry being written.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_data_q <= wr_i.data;
    end else begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/tss_ctrl.sv -----
// Sequencer control: step index, hold timer, park and fire state; decides one beat.
// Depends on tss_pkg; reads the table entry prefetched for the current step.
module tss_ctrl import tss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  item_t                 item_i,
  input  step_t                 entry_i,
  output tbl_wr_t               wr_o,
  output logic [STEP_IDX_W-1:0] rd_addr_o,
  output result_t               res_o
);

  logic [STEP_CNT_W-1:0] cur_q, cur_d;
  logic [STEP_CNT_W-1:0] total_q, total_d;
  logic                  active_q, active_d;
  logic                  hold_q, hold_d;
  logic                  park_q, park_d;
  logic [DELAY_W-1:0]    elapsed_q, elapsed_d;
  logic                  fire_q, fire_d;

  logic [STEP_CNT_W-1:0] cur_inc;
  logic [STEP_CNT_W-1:0] cnt_sat;
  logic                  tick_ok;
  logic                  park_now;
  logic                  is_ignite;
  logic                  done;

  assign cur_inc   = cur_q + STEP_CNT_W'(1);
  assign cnt_sat   = (32'(item_i.step_count) > MAX_STEPS) ? STEP_CNT_W'(MAX_STEPS)
                                                           : STEP_CNT_W'(item_i.step_count);
  assign tick_ok   = active_q && !park_q && (cur_q < total_q) &&
                     (32'(cur_q) < MAX_STEPS);
  assign is_ignite = (entry_i.kind == KIND_ACTION) && (entry_i.action == ACT_IGNITE);

  always_comb begin
    cur_d     = cur_q;
    total_d   = total_q;
    active_d  = active_q;
    hold_d    = hold_q;
    park_d    = park_q;
    elapsed_d = elapsed_q;
    fire_d    = fire_q;
    done      = 1'b0;
    park_now  = 1'b0;
    res_o     = '0;
    wr_o.en   = 1'b0;
    wr_o.addr = STEP_IDX_W'(item_i.step_addr);
    wr_o.data = item_i.entry;

    if (accept_i) begin
      case (item_i.mode)
        MODE_LOAD: begin
          if (!active_q && (32'(item_i.step_addr) < MAX_STEPS)) begin
            wr_o.en = 1'b1;
          end
        end
        MODE_START: begin
          if (!active_q) begin
            cur_d     = '0;
            hold_d    = 1'b0;
            park_d    = 1'b0;
            elapsed_d = '0;
            total_d   = cnt_sat;
            if (cnt_sat == '0) begin
              done = 1'b1;
            end else begin
              active_d = 1'b1;
            end
          end
        end
        MODE_CONFIRM: begin
          if (active_q && park_q) begin
            park_d = 1'b0;
            hold_d = 1'b0;
            cur_d  = cur_inc;
            if (cur_inc >= total_q) begin
              active_d  = 1'b0;
              cur_d     = '0;
              elapsed_d = '0;
              done      = 1'b1;
            end
          end
        end
        MODE_ABORT: begin
          fire_d    = 1'b0;
          active_d  = 1'b0;
          cur_d     = '0;
          hold_d    = 1'b0;
          park_d    = 1'b0;
          elapsed_d = '0;
        end
        MODE_TICK: begin
          if (tick_ok) begin
            if (!hold_q) begin
              elapsed_d = '0;
              case (entry_i.kind)
                KIND_SERVO: begin
                  res_o.servo_cmd  = 1'b1;
                  res_o.out_servo  = entry_i.servo;
                  res_o.out_preset = entry_i.preset;
                  hold_d           = 1'b1;
                end
                KIND_DELAY: begin
                  hold_d = 1'b1;
                end
                KIND_ACTION: begin
                  if (entry_i.action == ACT_IGNITE) begin
                    fire_d = 1'b1;
                  end else if (entry_i.action != ACT_NONE) begin
                    res_o.action_strobe = 1'b1;
                    res_o.out_action    = entry_i.action;
                  end
                  hold_d = 1'b1;
                end
                default: begin
                  park_d   = 1'b1;
                  park_now = 1'b1;
                end
              endcase
            end else if (elapsed_q != ELAPSED_MAX) begin
              elapsed_d = elapsed_q + DELAY_W'(1);
            end
            // Step delay over: drop an ignite and move to the next step.
            if (!park_now && hold_d && (elapsed_d >= entry_i.delay)) begin
              if (is_ignite) begin
                fire_d = 1'b0;
              end
              hold_d = 1'b0;
              cur_d  = cur_inc;
              if (cur_inc >= total_q) begin
                active_d  = 1'b0;
                cur_d     = '0;
                park_d    = 1'b0;
                elapsed_d = '0;
                done      = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    res_o.fire_line        = fire_d;
    res_o.busy_res         = active_d;
    res_o.awaiting_confirm = park_d;
    res_o.sequence_done    = done;
    res_o.step_now         = STEP_NOW_W'(cur_d);
  end

  // Prefetch the entry for whichever step is current next cycle.
  assign rd_addr_o = STEP_IDX_W'(cur_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      total_q   <= '0;
      active_q  <= 1'b0;
      hold_q    <= 1'b0;
      park_q    <= 1'b0;
      elapsed_q <= '0;
      fire_q    <= 1'b0;
    end else begin
      cur_q     <= cur_d;
      total_q   <= total_d;
      active_q  <= active_d;
      hold_q    <= hold_d;
      park_q    <= park_d;
      elapsed_q <= elapsed_d;
      fire_q    <= fire_d;
    end
  end

`ifndef ASSERT_OFF
  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (cur_q < total_q))
    else $error("step index ran past step count while busy");

  a_park_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    park_q |-> (active_q && !hold_q))
    else $error("parked without a running sequence or while holding");

  a_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_q |-> (active_q && hold_q))
    else $error("fire line high outside a held ignite step");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> !active_q)
    else $error("table written while a sequence runs");
`endif

endmodule

// ----- sv/timed_step_sequencer_unit.sv -----
// Top level of the timed step sequencer: channel handshakes and the result register.
// Depends on tss_pkg, tss_ifs, tss_step_mem and tss_ctrl.
//
// The block takes one event beat per clock (tick, start, confirm, abort or load) and
// returns exactly one result beat for each through a result register; the input
// stays ready while that register is empty or is being drained in the same cycle,
// so a downstream stall is the only thing that slows it. Each beat is decided
// combinationally: the step table sits in a 16-entry synchronous memory whose read port
// always fetches the entry of the step that will be current next cycle, so the entry is
// waiting when a tick arrives, and a load to that same entry is forwarded past the
// memory. The table has no reset and no clearing pass: run only steps that were loaded.
module timed_step_sequencer_unit import tss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tss_in_if.sink    in_i,
  tss_out_if.source out_o
);

  item_t                 item;
  step_t                 entry;
  tbl_wr_t               tbl_wr;
  logic [STEP_IDX_W-1:0] rd_addr;
  result_t               res;
  result_t               res_q;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;

  // Take a new beat whenever the result register is free or drains this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign item.mode         = in_i.mode;
  assign item.step_addr    = in_i.step_addr;
  assign item.step_count   = in_i.step_count;
  assign item.entry.kind   = in_i.step_kind;
  assign item.entry.servo  = in_i.servo_select;
  assign item.entry.preset = in_i.preset_index;
  assign item.entry.delay  = in_i.hold_ms;
  assign item.entry.action = in_i.action_code;

  tss_step_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (entry)
  );

  tss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (item),
    .entry_i   (entry),
    .wr_o      (tbl_wr),
    .rd_addr_o (rd_addr),
    .res_o     (res)
  );

  // Result register: load on accept, hold while the sink stalls.
  assign out_valid_d = accept || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.servo_cmd        = res_q.servo_cmd;
  assign out_o.out_servo        = res_q.out_servo;
  assign out_o.out_preset       = res_q.out_preset;
  assign out_o.fire_line        = res_q.fire_line;
  assign out_o.action_strobe    = res_q.action_strobe;
  assign out_o.out_action       = res_q.out_action;
  assign out_o.busy_res         = res_q.busy_res;
  assign out_o.awaiting_confirm = res_q.awaiting_confirm;
  assign out_o.sequence_done    = res_q.sequence_done;
  assign out_o.step_now         = res_q.step_now;

endmodule

// ----- verif/tb_timed_step_sequencer_unit.sv -----
// Self-checking testbench for timed_step_sequencer_unit: directed and random event beats.
// Needs tss_pkg, the tss_ifs channel interfaces and the sequencer RTL.
`timescale 1ns / 100ps

module tb_timed_step_sequencer_unit;
  import tss_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int RANDOM_EVENTS = 750;
  localparam int QUIET_TAIL    = 100;
  localparam int DRAIN_CYCLES  = 8;
  localparam int TICK_GUARD    = 60;

  // Modes the block does not decode; they must leave the state alone.
  localparam logic [MODE_W-1:0]   MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0]   MODE_UNUSED_LAST  = 3'd7;
  localparam logic [ACTION_W-1:0] ACT_LAST          = 4'hF;

  // Tracks the sequencer state beat by beat and holds the status each event should produce.
  class sequencer_tracker;
    step_t               steps [MAX_STEPS];
    logic [4:0]          cur_step;
    logic [4:0]          total;
    bit                  active;
    bit                  holding;
    bit                  parked;
    bit                  fire;
    logic [DELAY_W-1:0]  elapsed;
    result_t             status_due [$];
    int                  errors;
    int                  completions;
    int                  servo_seen;
    int                  strobe_seen;
    int                  ignitions;

    function new();
      go_idle();
      total       = '0;
      fire        = 1'b0;
      errors      = 0;
      completions = 0;
      servo_seen  = 0;
      strobe_seen = 0;
      ignitions   = 0;
    endfunction

    function void go_idle();
      active   = 1'b0;
      cur_step = '0;
      holding  = 1'b0;
      parked   = 1'b0;
      elapsed  = '0;
    endfunction

    // Move to the next step; report whether the sequence just ran out.
    function bit step_forward();
      cur_step++;
      holding = 1'b0;
      if (cur_step >= total) begin
        go_idle();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_event(item_t it);
      result_t r;
      step_t   s;
      bit      park_now;
      r        = '0;
      park_now = 1'b0;
      case (it.mode)
        MODE_LOAD: begin
          if (!active && it.step_addr < MAX_STEPS) steps[it.step_addr] = it.entry;
        end
        MODE_START: begin
          if (!active) begin
            go_idle();
            total = (it.step_count > MAX_STEPS) ? 5'(MAX_STEPS) : it.step_count;
            if (total == 0) r.sequence_done = 1'b1;
            else active = 1'b1;
          end
        end
        MODE_CONFIRM: begin
          if (active && parked) begin
            parked = 1'b0;
            r.sequence_done = step_forward();
          end
        end
        MODE_ABORT: begin
          fire = 1'b0;
          go_idle();
        end
        MODE_TICK: begin
          if (active && !parked && cur_step < total && cur_step < MAX_STEPS) begin
            s = steps[cur_step[3:0]];
            if (!holding) begin
              elapsed = '0;
              case (s.kind)
                KIND_SERVO: begin
                  r.servo_cmd  = 1'b1;
                  r.out_servo  = s.servo;
                  r.out_preset = s.preset;
                  holding      = 1'b1;
                end
                KIND_DELAY: holding = 1'b1;
                KIND_ACTION: begin
                  if (s.action == ACT_IGNITE) begin
                    fire = 1'b1;
                    ignitions++;
                  end else if (s.action != ACT_NONE) begin
                    r.action_strobe = 1'b1;
                    r.out_action    = s.action;
                  end
                  holding = 1'b1;
                end
                default: begin
                  parked   = 1'b1;
                  park_now = 1'b1;
                end
              endcase
            end else if (elapsed != ELAPSED_MAX) begin
              elapsed++;
            end
            // Hold until the delay has run out; an ignite drops its fire line here.
            if (!park_now && holding && elapsed >= s.delay) begin
              if (s.kind == KIND_ACTION && s.action == ACT_IGNITE) fire = 1'b0;
              r.sequence_done = step_forward();
            end
          end
        end
        default: ;
      endcase
      r.fire_line        = fire;
      r.busy_res         = active;
      r.awaiting_confirm = parked;
      r.step_now         = cur_step;
      if (r.sequence_done) completions++;
      if (r.servo_cmd) servo_seen++;
      if (r.action_strobe) strobe_seen++;
      status_due.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_status(result_t got);
      result_t want;
      if (status_due.size() == 0) begin
        $error("result beat arrived with no event outstanding");
        errors++;
        return;
      end
      want = status_due.pop_front();
      compare("servo_cmd", 32'(want.servo_cmd), 32'(got.servo_cmd));
      compare("out_servo", 32'(want.out_servo), 32'(got.out_servo));
      compare("out_preset", 32'(want.out_preset), 32'(got.out_preset));
      compare("fire_line", 32'(want.fire_line), 32'(got.fire_line));
      compare("action_strobe", 32'(want.action_strobe), 32'(got.action_strobe));
      compare("out_action", 32'(want.out_action), 32'(got.out_action));
      compare("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      compare("awaiting_confirm", 32'(want.awaiting_confirm), 32'(got.awaiting_confirm));
      compare("sequence_done", 32'(want.sequence_done), 32'(got.sequence_done));
      compare("step_now", 32'(want.step_now), 32'(got.step_now));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tss_in_if  in_if ();
  tss_out_if out_if ();

  timed_step_sequencer_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sequencer_tracker tracker;

  bit idle_on     = 1'b1;   // sender gaps enabled
  bit stall_on    = 1'b1;   // receiver stalls enabled
  int stall_left  = 0;
  int cycles      = 0;
  int beats_sent  = 0;
  int live_events = 0;
  int runs        = 0;

  // 12 ns clock: 6 ns high, 6 ns low.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, tracker.status_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: drive ready at the falling edge, stalling in bursts of random length.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else if (stall_on && $urandom_range(0, 9) == 0) begin
      out_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Check every result beat against the oldest outstanding status.
  always @(posedge clk_i) begin : result_monitor
    result_t got;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.servo_cmd        = out_if.servo_cmd;
      got.out_servo        = out_if.out_servo;
      got.out_preset       = out_if.out_preset;
      got.fire_line        = out_if.fire_line;
      got.action_strobe    = out_if.action_strobe;
      got.out_action       = out_if.out_action;
      got.busy_res         = out_if.busy_res;
      got.awaiting_confirm = out_if.awaiting_confirm;
      got.sequence_done    = out_if.sequence_done;
      got.step_now         = out_if.step_now;
      tracker.check_status(got);
    end
  end

  // Fill every field with random bits; callers override what matters.
  function automatic item_t random_event(logic [MODE_W-1:0] mode);
    logic [63:0] raw;
    item_t       it;
    raw     = {$urandom, $urandom};
    it      = raw[$bits(item_t)-1:0];
    it.mode = mode;
    return it;
  endfunction

  // Step contents: mostly short delays, some ignites, an occasional huge delay.
  function automatic step_t random_step();
    logic [63:0] raw;
    step_t       s;
    int          pick;
    raw  = {$urandom, $urandom};
    s    = raw[$bits(step_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 60) s.delay = $urandom_range(0, 3);
    else if (pick < 94) s.delay = $urandom_range(4, 12);
    if ($urandom_range(0, 3) == 0) s.action = ACT_IGNITE;
    return s;
  endfunction

  function automatic logic [MODE_W-1:0] noise_mode();
    case ($urandom_range(0, 3))
      0:       return MODE_START;
      1:       return MODE_CONFIRM;
      2:       return MODE_LOAD;
      default: return MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
    endcase
  endfunction

  // Present one event beat at the falling edge and hold it until accepted.
  task automatic send_event(item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.mode         <= it.mode;
    in_if.step_addr    <= it.step_addr;
    in_if.step_kind    <= it.entry.kind;
    in_if.servo_select <= it.entry.servo;
    in_if.preset_index <= it.entry.preset;
    in_if.hold_ms      <= it.entry.delay;
    in_if.action_code  <= it.entry.action;
    in_if.step_count   <= it.step_count;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tracker.note_event(it);
    beats_sent++;
  endtask

  task automatic send_mode(logic [MODE_W-1:0] mode);
    send_event(random_event(mode));
  endtask

  task automatic load_step(logic [ADDR_W-1:0] addr, logic [KIND_W-1:0] kind,
                           logic [SERVO_W-1:0] servo, logic [PRESET_W-1:0] preset,
                           logic [DELAY_W-1:0] delay, logic [ACTION_W-1:0] action);
    item_t it;
    it              = random_event(MODE_LOAD);
    it.step_addr    = addr;
    it.entry.kind   = kind;
    it.entry.servo  = servo;
    it.entry.preset = preset;
    it.entry.delay  = delay;
    it.entry.action = action;
    send_event(it);
  endtask

  task automatic start_run(logic [COUNT_W-1:0] count);
    item_t it;
    it            = random_event(MODE_START);
    it.step_count = count;
    send_event(it);
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (tracker.status_due.size() != 0) @(posedge clk_i);
  endtask

  // One well-formed run: load a table, start it, tick and confirm it through,
  // with some noise mixed in. Abort if a long delay keeps it busy too long.
  task automatic run_sequence(int length);
    item_t it;
    int    guard;
    int    pick;
    for (int i = 0; i < length; i++) begin
      it           = random_event(MODE_LOAD);
      it.step_addr = ADDR_W'(i);
      it.entry     = random_step();
      send_event(it);
      live_events++;
    end
    it = random_event(MODE_START);
    if ($urandom_range(0, 4) != 0) it.step_count = COUNT_W'(length);
    send_event(it);
    live_events++;
    guard = 0;
    while (tracker.active && guard < TICK_GUARD) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_mode(MODE_ABORT);
        live_events++;
      end else if (pick < 10) begin
        send_mode(noise_mode());
      end else if (tracker.parked) begin
        send_mode(MODE_CONFIRM);
        live_events++;
      end else begin
        send_mode(MODE_TICK);
        live_events++;
      end
      guard++;
    end
    if (tracker.active) begin
      send_mode(MODE_ABORT);
      live_events++;
    end
  endtask

  initial begin
    tracker             = new();
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.mode          = MODE_TICK;
    in_if.step_addr     = '0;
    in_if.step_kind     = KIND_SERVO;
    in_if.servo_select  = '0;
    in_if.preset_index  = '0;
    in_if.hold_ms       = '0;
    in_if.action_code   = ACT_NONE;
    in_if.step_count    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Idle behavior: tick, confirm and abort do nothing, an empty start finishes at once,
    // an undecoded mode is ignored.
    send_mode(MODE_TICK);
    send_mode(MODE_CONFIRM);
    send_mode(MODE_ABORT);
    start_run('0);
    send_mode(MODE_UNUSED_LAST);

    // Table covering every step kind, ignite, a generic strobe, a no-op action,
    // zero delays and a closing wait-for-confirm.
    load_step(4'd0, KIND_SERVO, 8'hFF, 4'hF, '0, ACT_NONE);
    load_step(4'd1, KIND_ACTION, '0, '0, 32'd1, ACT_IGNITE);
    load_step(4'd2, KIND_ACTION, '0, '0, '0, ACT_LAST);
    load_step(4'd3, KIND_DELAY, '0, '0, 32'd1, ACT_NONE);
    load_step(4'd4, KIND_ACTION, '0, '0, '0, ACT_NONE);
    load_step(4'd5, KIND_WAIT, '0, '0, '0, ACT_NONE);
    start_run(5'd6);
    repeat (8) send_mode(MODE_TICK);
    send_mode(MODE_TICK);                                // parked: tick is a no-op
    start_run(COUNT_W'(MAX_STEPS));                      // busy: start is dropped
    load_step(4'd15, KIND_SERVO, '0, '0, '1, ACT_NONE);  // busy: load is dropped
    send_mode(MODE_CONFIRM);                             // confirm past the last step
    // Abort while the fire line is up.
    start_run(5'd2);
    send_mode(MODE_TICK);
    send_mode(MODE_TICK);
    send_mode(MODE_ABORT);
    wait_drained();

    // The first random run loads the whole table so no later start can reach an
    // entry that was never written.
    run_sequence(MAX_STEPS);
    runs++;
    while (live_events < RANDOM_EVENTS) begin
      if (live_events > RANDOM_EVENTS - QUIET_TAIL) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0:       send_mode(MODE_TICK);
          1:       send_mode(MODE_CONFIRM);
          2:       send_mode(MODE_ABORT);
          default: send_mode(MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)));
        endcase
      end
      run_sequence(($urandom_range(0, 9) == 0) ? MAX_STEPS : $urandom_range(1, 6));
      runs++;
      if (runs % 8 == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d event beats over %0d table runs in %0d cycles.",
             beats_sent, runs, cycles);
    $display("Seen %0d completions, %0d servo commands, %0d strobes, %0d ignitions.",
             tracker.completions, tracker.servo_seen, tracker.strobe_seen, tracker.ignitions);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- timed_step_sequencer_unit.f -----
sv/tss_pkg.sv
sv/tss_ifs.sv
sv/tss_step_mem.sv
sv/tss_ctrl.sv
sv/timed_step_sequencer_unit.sv
verif/tb_timed_step_sequencer_unit.sv
